// ===== rtl/core/kmd_pkg.sv =====
// Shared types and constants for the key matrix debouncer.
package kmd_pkg;

  localparam int unsigned NumColumns = 8;
  localparam int unsigned NumRows    = 5;
  localparam int unsigned KeyWidth   = 40;
  localparam int unsigned KeyBits    = NumColumns * NumRows;

  localparam int unsigned StableWidth = 8;
  localparam int unsigned IdleWidth   = 16;
  localparam int unsigned AddrWidth   = 3;
  localparam int unsigned DataWidth   = 32;

  localparam logic [StableWidth-1:0] StableReset = 8'd5;
  localparam logic [IdleWidth-1:0]   IdleReset   = 16'd500;

  // Register index, taken from paddr[2]
  localparam logic RegStable = 1'b0;
  localparam logic RegIdle   = 1'b1;

  typedef enum logic [1:0] {
    OpScan  = 2'd0,
    OpMaint = 2'd1,
    OpWake  = 2'd2
  } op_e;

  typedef struct packed {
    logic [StableWidth-1:0] stable_scans_needed;
    logic [IdleWidth-1:0]   idle_limit;
  } cfg_t;

  typedef struct packed {
    logic                send_valid;
    logic [KeyWidth-1:0] report_keys;
    logic                sleep_request;
  } result_t;

  typedef struct packed {
    logic                asleep;
    logic [KeyWidth-1:0] accepted_keys;
  } status_t;

  function automatic logic [KeyWidth-1:0] used_key_mask();
    logic [KeyWidth-1:0] mask;
    for (int unsigned i = 0; i < KeyWidth; i++) begin
      mask[i] = (i < KeyBits);
    end
    return mask;
  endfunction

endpackage

// ===== rtl/core/kmd_cfg_regs.sv =====
// Configuration register file behind the APB-style port.
module kmd_cfg_regs import kmd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stable_scans_needed <= StableReset;
      cfg_q.idle_limit          <= IdleReset;
    end else if (wr_en) begin
      case (paddr[2])
        RegStable: cfg_q.stable_scans_needed <= pwdata[StableWidth-1:0];
        RegIdle:   cfg_q.idle_limit          <= pwdata[IdleWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegStable: prdata = {{(DataWidth-StableWidth){1'b0}}, cfg_q.stable_scans_needed};
      RegIdle:   prdata = {{(DataWidth-IdleWidth){1'b0}}, cfg_q.idle_limit};
      default:   prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/kmd_engine.sv =====
// Debounce and idle state with the per-item update logic.
module kmd_engine import kmd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [1:0]          opcode_i,
  input  logic [KeyWidth-1:0] key_matrix_i,
  input  cfg_t                cfg_i,
  output result_t             result_o,
  output status_t             status_o
);

  typedef struct packed {
    logic [KeyWidth-1:0]    accepted;
    logic [KeyWidth-1:0]    snapshot;
    logic                   debouncing;
    logic [StableWidth-1:0] match_count;
    logic [IdleWidth-1:0]   idle_count;
    logic                   asleep;
  } state_t;

  state_t state_q, state_d;

  logic [KeyWidth-1:0]    scan;
  logic [StableWidth-1:0] match_inc;
  logic [IdleWidth-1:0]   idle_inc;
  logic                   send, sleep_req;

  assign scan      = key_matrix_i & used_key_mask();
  assign match_inc = state_q.match_count + StableWidth'(1);
  assign idle_inc  = (&state_q.idle_count) ? state_q.idle_count
                                           : state_q.idle_count + IdleWidth'(1);

  always_comb begin
    state_d   = state_q;
    send      = 1'b0;
    sleep_req = 1'b0;
    case (op_e'(opcode_i))
      OpWake: begin
        state_d.idle_count = '0;
        state_d.asleep     = 1'b0;
      end
      OpMaint: begin
        send = !state_q.asleep;
      end
      OpScan: begin
        if (!state_q.asleep) begin
          if (state_q.debouncing) begin
            if (scan == state_q.snapshot) begin
              // saturate: accept only on the increment that hits the target
              if (!(&state_q.match_count)) begin
                state_d.match_count = match_inc;
                if (match_inc == cfg_i.stable_scans_needed) begin
                  state_d.accepted = state_q.snapshot;
                  send             = 1'b1;
                end
              end
            end else begin
              state_d.debouncing = 1'b0;
            end
          end else if (scan != state_q.accepted) begin
            state_d.snapshot    = scan;
            state_d.debouncing  = 1'b1;
            state_d.match_count = '0;
          end

          if (scan == '0) begin
            state_d.idle_count = idle_inc;
            if (idle_inc > cfg_i.idle_limit) begin
              sleep_req      = 1'b1;
              state_d.asleep = 1'b1;
            end
          end else begin
            state_d.idle_count = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance_i) begin
      state_q <= state_d;
    end
  end

  assign result_o.send_valid    = send;
  assign result_o.report_keys   = state_d.accepted;
  assign result_o.sleep_request = sleep_req;

  assign status_o.asleep        = state_q.asleep;
  assign status_o.accepted_keys = state_q.accepted;

endmodule

// ===== rtl/core/key_matrix_debounce_idle.sv =====
// Top level of the key matrix debouncer with idle sleep.
// Each item (scan tick, maintenance tick or wake event) gives exactly one
// result item. An item is held in an input register, updated against the
// debounce state by one level of compare and counter logic, and captured in
// an output register, so the block takes one item per clock cycle unless the
// output stalls; a stall on the output holds the result register and then the
// input register, after which the input side stalls. Configuration goes
// through the APB-style port: stable_scans_needed at byte address 0, idle_limit
// at 4. The user must write each only while no item is in flight; not enforced.
module key_matrix_debounce_idle import kmd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           opcode_i,
  input  logic [KeyWidth-1:0]  key_matrix_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 send_valid_o,
  output logic [KeyWidth-1:0]  report_keys_o,
  output logic                 sleep_request_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  cfg_t    cfg;
  result_t step_res;
  status_t status;
  result_t res_q;

  logic                in_valid_q, out_valid_q;
  logic [1:0]          opcode_q;
  logic [KeyWidth-1:0] keys_q;
  logic                advance, in_take;

  // move the held item into the result register when that is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  kmd_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  kmd_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .advance_i    (advance),
    .opcode_i     (opcode_q),
    .key_matrix_i (keys_q),
    .cfg_i        (cfg),
    .result_o     (step_res),
    .status_o     (status)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      opcode_q <= opcode_i;
      keys_q   <= key_matrix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= step_res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = res_q.send_valid;
  assign report_keys_o   = res_q.report_keys;
  assign sleep_request_o = res_q.sleep_request;

`ifndef SYNTHESIS
  a_sleep_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && step_res.sleep_request |=> status.asleep)
    else $error("sleep request did not put the engine to sleep");

  a_asleep_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && status.asleep && (opcode_q != OpWake)
      |-> !step_res.send_valid && !step_res.sleep_request)
    else $error("asleep engine produced a report or sleep request");

  a_keys_only_on_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !step_res.send_valid |-> step_res.report_keys == status.accepted_keys)
    else $error("accepted keys changed without a report");

  a_input_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(opcode_q) && $stable(keys_q))
    else $error("held input item lost or changed");
`endif

endmodule

// ===== verif/tb_key_matrix_debounce_idle.sv =====
// Self-checking testbench for the key matrix debouncer with idle sleep.
`timescale 1ns / 1ps

module tb_key_matrix_debounce_idle;
  import kmd_pkg::*;

  localparam int unsigned TimeoutCycles = 10_000_000;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned MaxReports    = 10;

  localparam logic [1:0]           OpReserved = 2'd3;
  localparam logic [AddrWidth-1:0] AddrStable = {RegStable, 2'b00};
  localparam logic [AddrWidth-1:0] AddrIdle   = {RegIdle, 2'b00};
  localparam logic [KeyWidth-1:0]  KeyMask    = {KeyWidth{1'b1}} >> (KeyWidth - KeyBits);
  localparam logic [KeyWidth-1:0]  AllKeys    = {KeyWidth{1'b1}};

  // Debounce predictor plus the queue of results it is waiting for.
  class debounce_scoreboard;
    logic [StableWidth-1:0] stable_needed;
    logic [IdleWidth-1:0]   idle_lim;
    logic [KeyWidth-1:0]    accepted;
    logic [KeyWidth-1:0]    snapshot;
    bit                     debouncing;
    logic [StableWidth-1:0] match_cnt;
    logic [IdleWidth-1:0]   idle_cnt;
    bit                     asleep;
    result_t                pending_q[$];
    int unsigned            items, results, reports, sleeps, errors;
    int unsigned            match_sats, idle_sats;

    function void reset();
      stable_needed = StableReset;
      idle_lim      = IdleReset;
      accepted      = '0;
      snapshot      = '0;
      debouncing    = 1'b0;
      match_cnt     = '0;
      idle_cnt      = '0;
      asleep        = 1'b0;
      pending_q.delete();
    endfunction

    function void set_reg(logic idx, logic [DataWidth-1:0] value);
      if (idx == RegStable) stable_needed = value[StableWidth-1:0];
      else idle_lim = value[IdleWidth-1:0];
    endfunction

    function void note_input(logic [1:0] op, logic [KeyWidth-1:0] keys);
      logic [KeyWidth-1:0] scan;
      result_t             exp;
      scan  = keys & KeyMask;
      exp   = '0;
      items++;
      case (op)
        OpWake: begin
          idle_cnt = '0;
          asleep   = 1'b0;
        end
        OpMaint: begin
          if (!asleep) exp.send_valid = 1'b1;
        end
        OpScan: begin
          if (!asleep) begin
            if (debouncing) begin
              if (scan == snapshot) begin
                if (match_cnt != '1) begin
                  match_cnt++;
                  if (match_cnt == stable_needed) begin
                    accepted       = snapshot;
                    exp.send_valid = 1'b1;
                  end
                end else begin
                  match_sats++;
                end
              end else begin
                debouncing = 1'b0;
              end
            end else if (scan != accepted) begin
              snapshot   = scan;
              debouncing = 1'b1;
              match_cnt  = '0;
            end
            if (scan == '0) begin
              if (idle_cnt != '1) idle_cnt++;
              else idle_sats++;
              if (idle_cnt > idle_lim) begin
                exp.sleep_request = 1'b1;
                asleep            = 1'b1;
              end
            end else begin
              idle_cnt = '0;
            end
          end
        end
        default: ;
      endcase
      exp.report_keys = accepted;
      if (exp.send_valid) reports++;
      if (exp.sleep_request) sleeps++;
      pending_q.push_back(exp);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      results++;
      if (pending_q.size() == 0) begin
        if (errors < MaxReports)
          $display("ERROR: unexpected result item send=%0b keys=%h sleep=%0b",
                   got.send_valid, got.report_keys, got.sleep_request);
        errors++;
        return;
      end
      exp = pending_q.pop_front();
      if (got != exp) begin
        if (errors < MaxReports)
          $display("ERROR: result %0d: expected send=%0b keys=%h sleep=%0b,",
                   results, exp.send_valid, exp.report_keys, exp.sleep_request,
                   " got send=%0b keys=%h sleep=%0b",
                   got.send_valid, got.report_keys, got.sleep_request);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           opcode_i = '0;
  logic [KeyWidth-1:0]  key_matrix_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic                 send_valid_o;
  logic [KeyWidth-1:0]  report_keys_o;
  logic                 sleep_request_o;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  debounce_scoreboard sb;
  int unsigned        burst_left = 0;
  int unsigned        hold_req = 0;
  int unsigned        hold_seen = 0;
  int unsigned        settings = 0;

  key_matrix_debounce_idle dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .opcode_i,
    .key_matrix_i,
    .out_valid_o,
    .out_stall_i,
    .send_valid_o,
    .report_keys_o,
    .sleep_request_o,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic write_reg(input logic idx, input logic [DataWidth-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= (idx == RegStable) ? AddrStable : AddrIdle;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task automatic set_config(input int unsigned stable, input int unsigned idle);
    write_reg(RegStable, stable);
    write_reg(RegIdle, idle);
    settings++;
  endtask

  // Offer one item in bursts separated by random gaps; return once accepted.
  task automatic send_item(input logic [1:0] op, input logic [KeyWidth-1:0] keys);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    key_matrix_i <= keys;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(op, keys);
    burst_left--;
  endtask

  // Drop valid and wait until every result item has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [KeyWidth-1:0] pick_keys();
    logic [KeyWidth-1:0] k;
    case ($urandom_range(0, 3))
      0: k = '0;
      1: k = KeyWidth'(1) << $urandom_range(0, KeyWidth - 1);
      2: k = (KeyWidth'(1) << $urandom_range(0, KeyWidth - 1))
           | (KeyWidth'(1) << $urandom_range(0, KeyWidth - 1));
      default: k = KeyWidth'({$urandom, $urandom});
    endcase
    return k;
  endfunction

  // Mostly press episodes and idle stretches, with bounces and stray events mixed in.
  task automatic run_random(input int unsigned n_items);
    int unsigned         done;
    int unsigned         reps;
    int unsigned         lim;
    logic [KeyWidth-1:0] pat;
    done = 0;
    while (done < n_items) begin
      pat = pick_keys();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          reps = $urandom_range(1, sb.stable_needed + 3);
          repeat (reps) begin
            if ($urandom_range(0, 15) == 0)
              send_item(OpScan, pat ^ (KeyWidth'(1) << $urandom_range(0, KeyWidth - 1)));
            else
              send_item(OpScan, pat);
            done++;
          end
        end
        6, 7: begin
          lim  = (sb.idle_lim > 40) ? 40 : sb.idle_lim + 3;
          reps = $urandom_range(1, lim);
          repeat (reps) begin
            send_item(OpScan, '0);
            done++;
          end
        end
        8: begin
          send_item(OpMaint, pat);
          done++;
        end
        default: begin
          if ($urandom_range(0, 1) == 0) send_item(OpWake, pat);
          else send_item(2'($urandom_range(0, 3)), KeyWidth'({$urandom, $urandom}));
          done++;
        end
      endcase
    end
  endtask

  // Receiver: check accepted results, stall on a rolling pattern, long hold-off on request.
  initial begin : receiver
    logic [15:0] stall_pat;
    int unsigned pat_pos;
    int unsigned hold_left;
    stall_pat = '0;
    pat_pos   = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result({send_valid_o, report_keys_o, sleep_request_o});
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (pat_pos == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pat = '0;
            1: stall_pat = 16'($urandom & $urandom);
            2: stall_pat = 16'($urandom);
            default: stall_pat = 16'($urandom | $urandom);
          endcase
        end
        out_stall_i <= stall_pat[pat_pos % 16];
        pat_pos = (pat_pos + 1) % 64;
      end
    end
  end

  initial begin : watchdog
    repeat (TimeoutCycles) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    sb.reset();
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short limits so acceptance, abort and sleep show up quickly.
    set_config(2, 3);
    send_item(OpMaint, '0);
    send_item(OpScan, AllKeys);
    send_item(OpScan, AllKeys);
    send_item(OpScan, AllKeys);
    send_item(OpMaint, '0);
    send_item(OpScan, 40'h00_0000_0001);
    send_item(OpScan, 40'h00_0000_0001);
    send_item(OpScan, 40'h00_0000_0002);
    send_item(OpReserved, AllKeys);
    send_item(OpWake, '0);
    repeat (4) send_item(OpScan, '0);
    send_item(OpScan, AllKeys);
    send_item(OpMaint, AllKeys);
    send_item(OpReserved, '0);
    send_item(OpWake, AllKeys);
    send_item(OpScan, '0);
    send_item(OpScan, 40'h80_0000_0000);
    send_item(OpScan, 40'h55_5555_5555);
    send_item(OpScan, 40'hAA_AAAA_AAAA);
    send_item(OpScan, 40'hAA_AAAA_AAAA);
    drain();

    // Zero threshold: nothing is ever accepted.
    set_config(0, 2);
    run_random(60);
    drain();

    set_config(1, 1);
    run_random(80);
    drain();

    // Long receiver hold-off while the sender keeps going.
    set_config(3, 10);
    hold_req++;
    run_random(120);
    drain();

    // Largest threshold, then hold the same keys long enough to saturate the match count.
    set_config(8'hFF, 40);
    send_item(OpWake, '0);
    repeat (262) send_item(OpScan, 40'h00_0000_0420);
    run_random(30);
    drain();

    // Largest idle limit: a long idle stretch must leave the block awake.
    set_config(7, 16'hFFFF);
    send_item(OpWake, '0);
    send_item(OpScan, 40'h01_0000_0000);
    repeat (60) send_item(OpScan, '0);
    run_random(20);
    drain();

    set_config(StableReset, IdleReset);
    hold_req++;
    run_random(60);
    drain();

    set_config($urandom_range(1, 12), $urandom_range(1, 30));
    run_random(60);
    drain();

    if (sb.pending_q.size() != 0) begin
      $display("ERROR: %0d expected result items never arrived", sb.pending_q.size());
      sb.errors++;
    end
    $display("Ran %0d items over %0d register settings: %0d reports, %0d sleep requests.",
             sb.items, settings, sb.reports, sb.sleeps);
    $display("Match count held at saturation %0d times, idle count %0d times; %0d mismatches.",
             sb.match_sats, sb.idle_sats, sb.errors);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/kmd_pkg.sv
rtl/core/kmd_cfg_regs.sv
rtl/core/kmd_engine.sv
rtl/core/key_matrix_debounce_idle.sv
verif/tb_key_matrix_debounce_idle.sv
